/* rtl/wcs_pkg.sv */
`default_nettype none

package wcs_pkg;

  // phase codes, also the value of the phase field
  localparam logic [3:0] PH_OFF      = 4'd0;
  localparam logic [3:0] PH_FILL     = 4'd1;
  localparam logic [3:0] PH_HEAT     = 4'd2;
  localparam logic [3:0] PH_WASH     = 4'd3;
  localparam logic [3:0] PH_PUMPSPIN = 4'd4;
  localparam logic [3:0] PH_SPIN     = 4'd5;
  localparam logic [3:0] PH_STOP     = 4'd6;
  localparam logic [3:0] PH_ABORT    = 4'd7;
  localparam logic [3:0] PH_DRAIN    = 4'd8;
  localparam logic [3:0] PH_DONE     = 4'd9;

  // port one: at most one of valve, heater, pump
  localparam logic [1:0] P1_NONE   = 2'd0;
  localparam logic [1:0] P1_VALVE  = 2'd1;
  localparam logic [1:0] P1_HEATER = 2'd2;
  localparam logic [1:0] P1_PUMP   = 2'd3;

  // port zero: drum motor
  localparam logic [1:0] P0_OFF  = 2'd0;
  localparam logic [1:0] P0_ON   = 2'd1;
  localparam logic [1:0] P0_SPIN = 2'd2;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_TICKS_PER_SECOND  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_WASH_SECONDS      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PUMP_SPIN_SECONDS = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SPIN_SECONDS      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DRAIN_SECONDS     = 3'd4;

  localparam logic [7:0] TICKS_PER_SECOND_RST  = 8'd183;
  localparam logic [7:0] WASH_SECONDS_RST      = 8'd30;
  localparam logic [7:0] PUMP_SPIN_SECONDS_RST = 8'd10;
  localparam logic [7:0] SPIN_SECONDS_RST      = 8'd20;
  localparam logic [7:0] DRAIN_SECONDS_RST     = 8'd10;

  localparam logic [7:0] SECONDS_MAX = 8'hFF;

  typedef struct packed {
    logic tick;
    logic main_switch;
    logic hot_select;
    logic level_reached;
    logic at_ninety;
    logic at_sixty;
    logic abort_request;
  } in_item_t;

  typedef struct packed {
    logic       valve_open;
    logic       heater_on;
    logic       pump_on;
    logic       motor_on;
    logic       spin_on;
    logic [3:0] phase;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/wash_cycle_sequencer.sv */
`default_nettype none

// Washing machine program sequencer. Each accepted item is one sample of the
// base-timer tick flag, switches, sensors and abort button; it yields exactly one
// result item with the valve, heater, pump, motor and spin drives and the phase
// code after the update. An item is taken every cycle when not stalled; its
// result is registered in the output register, set by a single pass of next-state
// logic over the phase, seconds and prescaler registers. While a result waits
// under stall the input is stalled too. Configuration registers (ticks per
// second and the phase durations in seconds) are written through the cfg
// channel, which is always ready; indexes past the last register are ignored.
module wash_cycle_sequencer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire wcs_pkg::in_item_t              in_item_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      wcs_pkg::out_item_t             out_item_o,
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [wcs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [7:0]                     cfg_data_i
);
  import wcs_pkg::*;

  logic [7:0] tps_q, wash_secs_q, pspin_secs_q, spin_secs_q, drain_secs_q;

  logic [3:0] phase_q, phase_d, phase_ab;
  logic [7:0] secs_q, secs_d, secs_tick;
  logic [7:0] presc_q, presc_d;
  logic [8:0] presc_inc;
  logic [1:0] p1_sel_q, p1_sel_d;
  logic [1:0] p0_sel_q, p0_sel_d;

  logic       out_valid_q;
  out_item_t  out_item_q, out_item_d;
  logic       in_accept;
  logic       hot_enough;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q        <= TICKS_PER_SECOND_RST;
      wash_secs_q  <= WASH_SECONDS_RST;
      pspin_secs_q <= PUMP_SPIN_SECONDS_RST;
      spin_secs_q  <= SPIN_SECONDS_RST;
      drain_secs_q <= DRAIN_SECONDS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TICKS_PER_SECOND:  tps_q        <= cfg_data_i;
        REG_WASH_SECONDS:      wash_secs_q  <= cfg_data_i;
        REG_PUMP_SPIN_SECONDS: pspin_secs_q <= cfg_data_i;
        REG_SPIN_SECONDS:      spin_secs_q  <= cfg_data_i;
        REG_DRAIN_SECONDS:     drain_secs_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign hot_enough = in_item_i.hot_select ? in_item_i.at_ninety : in_item_i.at_sixty;
  assign presc_inc  = {1'b0, presc_q} + 9'd1;

  always_comb begin
    presc_d   = presc_q;
    secs_tick = secs_q;
    // zero ticks per second makes every tick a full second
    if (in_item_i.tick) begin
      if (presc_inc >= {1'b0, tps_q}) begin
        presc_d = '0;
        if (secs_q != SECONDS_MAX) secs_tick = secs_q + 8'd1;
      end else begin
        presc_d = presc_inc[7:0];
      end
    end

    phase_ab = phase_q;
    if (in_item_i.abort_request && phase_q != PH_OFF && phase_q != PH_DONE)
      phase_ab = PH_ABORT;

    phase_d  = phase_ab;
    secs_d   = secs_tick;
    p1_sel_d = p1_sel_q;
    p0_sel_d = p0_sel_q;

    unique case (phase_ab)
      PH_OFF: begin
        if (in_item_i.main_switch) phase_d = PH_FILL;
      end
      PH_FILL: begin
        if (in_item_i.level_reached) begin
          p1_sel_d = P1_NONE;
          phase_d  = PH_HEAT;
          secs_d   = '0;
        end else begin
          p1_sel_d = P1_VALVE;
        end
      end
      PH_HEAT: begin
        if (!hot_enough) begin
          p1_sel_d = P1_HEATER;
        end else begin
          phase_d = PH_WASH;
          secs_d  = '0;
        end
      end
      PH_WASH: begin
        if (secs_tick >= wash_secs_q) begin
          phase_d = PH_PUMPSPIN;
          secs_d  = '0;
        end else begin
          // thermostat during the wash
          p1_sel_d = hot_enough ? P1_NONE : P1_HEATER;
        end
        p0_sel_d = P0_ON;
      end
      PH_PUMPSPIN: begin
        if (secs_tick >= pspin_secs_q) begin
          phase_d = PH_SPIN;
          secs_d  = '0;
        end else begin
          p0_sel_d = P0_SPIN;
          p1_sel_d = P1_PUMP;
        end
      end
      PH_SPIN: begin
        if (secs_tick >= spin_secs_q) begin
          phase_d = PH_STOP;
        end else begin
          p0_sel_d = P0_SPIN;
          p1_sel_d = P1_NONE;
        end
      end
      PH_STOP: begin
        p0_sel_d = P0_OFF;
        phase_d  = PH_DONE;
      end
      PH_ABORT: begin
        p0_sel_d = P0_OFF;
        p1_sel_d = P1_PUMP;
        phase_d  = PH_DRAIN;
        secs_d   = '0;
      end
      PH_DRAIN: begin
        if (secs_tick >= drain_secs_q) begin
          p1_sel_d = P1_NONE;
          phase_d  = PH_DONE;
        end
      end
      PH_DONE: begin
        if (!in_item_i.main_switch) phase_d = PH_OFF;
      end
      default: phase_d = PH_OFF;
    endcase

    out_item_d.valve_open = (p1_sel_d == P1_VALVE);
    out_item_d.heater_on  = (p1_sel_d == P1_HEATER);
    out_item_d.pump_on    = (p1_sel_d == P1_PUMP);
    out_item_d.motor_on   = (p0_sel_d == P0_ON) || (p0_sel_d == P0_SPIN);
    out_item_d.spin_on    = (p0_sel_d == P0_SPIN);
    out_item_d.phase      = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OFF;
      secs_q      <= '0;
      presc_q     <= '0;
      p1_sel_q    <= P1_NONE;
      p0_sel_q    <= P0_OFF;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_q  <= phase_d;
        secs_q   <= secs_d;
        presc_q  <= presc_d;
        p1_sel_q <= p1_sel_d;
        p0_sel_q <= p0_sel_d;
      end
      if (!in_stall_o) out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) out_item_q <= out_item_d;
  end

  // an abort in an active phase always lands in drain with the pump running
  a_abort_to_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_item_i.abort_request && phase_q != PH_OFF && phase_q != PH_DONE
    |=> out_valid_o && out_item_o.phase == PH_DRAIN && out_item_o.pump_on)
    else $error("abort did not lead to drain");

  a_spin_needs_motor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_item_o.spin_on || out_item_o.motor_on))
    else $error("spin without motor");

  a_drives_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({out_item_o.valve_open, out_item_o.heater_on,
                              out_item_o.pump_on}))
    else $error("port one drives more than one load");

  a_result_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_item_o.phase == phase_q)
    else $error("result phase differs from phase register");

endmodule

`default_nettype wire
